>>> sv/rsrs_pkg.sv
// ----------------------------------------------------------------------------
// rsrs_pkg
// Shared types, constants and clamp helpers for the stripe request splitter.
// ----------------------------------------------------------------------------
package rsrs_pkg;

	localparam int POL_SLOTS    = 4;
	localparam int MAX_POL_DEF  = 4;
	localparam int KIB_W        = 17;
	localparam int NPOL_W       = 3;
	localparam int SRVW_W       = 9;
	localparam int SRV_W        = 8;
	localparam int BASE_W       = 48;
	localparam int SIZE_W       = 21;
	localparam int LOW_W        = 10;
	localparam int DIV_BITS     = BASE_W - LOW_W;
	localparam int CNT_W        = 6;
	localparam int OBJ_W        = 43;
	localparam int OFF_W        = 26;
	localparam int LEN_W        = 27;
	localparam int BUF_W        = 20;
	localparam int IDX_W        = 3;

	localparam logic [KIB_W-1:0]  KIB_MIN    = 17'd32;
	localparam logic [KIB_W-1:0]  KIB_MAX    = 17'd65536;
	localparam logic [KIB_W-1:0]  KIB_RST    = 17'd128;
	localparam logic [NPOL_W-1:0] NPOL_RST   = 3'd1;
	localparam logic [SRVW_W-1:0] SRVW_RST   = 9'd1;
	localparam logic [SRVW_W-1:0] SRVW_MAX   = 9'd256;
	localparam logic [SIZE_W-1:0] SIZE_BOUND = 21'h100000;
	localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(DIV_BITS - 1);

	typedef enum logic [IDX_W-1:0] {
		REG_STRIPE_KIB   = 3'd0,
		REG_POLICY_COUNT = 3'd1,
		REG_WIDTH_0      = 3'd2,
		REG_WIDTH_1      = 3'd3,
		REG_WIDTH_2      = 3'd4,
		REG_WIDTH_3      = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_PUSH
	} front_state_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [KIB_W-1:0]                    kib;
		logic [NPOL_W-1:0]                   npol;
		logic [POL_SLOTS-1:0][SRVW_W-1:0]    width;
	} cfg_t;

	// one classified request handed from front to back
	typedef struct packed {
		logic                                kind;
		logic [DIV_BITS-1:0]                 obj;
		logic [OFF_W-1:0]                    off;
		logic [SIZE_W-1:0]                   size;
		logic [POL_SLOTS-1:0][SRV_W-1:0]     srv;
	} job_t;

	function automatic logic [KIB_W-1:0] clamp_kib(input logic [KIB_W-1:0] v);
		if (v < KIB_MIN) return KIB_MIN;
		if (v > KIB_MAX) return KIB_MAX;
		return v;
	endfunction

	function automatic logic [NPOL_W-1:0] clamp_npol(input logic [NPOL_W-1:0] v,
		input logic [NPOL_W-1:0] top);
		if (v == '0) return NPOL_RST;
		if (v > top) return top;
		return v;
	endfunction

	function automatic logic [SRVW_W-1:0] clamp_width(input logic [SRVW_W-1:0] v);
		if (v == '0) return SRVW_RST;
		if (v > SRVW_MAX) return SRVW_MAX;
		return v;
	endfunction

endpackage

>>> sv/raid0_stripe_request_splitter_unit.sv
// ----------------------------------------------------------------------------
// raid0_stripe_request_splitter_unit
// The front divides each request with a one-bit-per-cycle divider (38
// quotient bits) and takes no new request until it has handed the last one on;
// chunks of a request leave one per cycle while out_ready is high.
// Reset clears all control state and loads the register reset values.
// ----------------------------------------------------------------------------
module raid0_stripe_request_splitter_unit #(
	parameter int MAX_POLICIES = rsrs_pkg::MAX_POL_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rsrs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [rsrs_pkg::KIB_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [rsrs_pkg::BASE_W-1:0]   byte_offset,
	input  logic [rsrs_pkg::SIZE_W-1:0]   byte_size,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [rsrs_pkg::OBJ_W-1:0]    object_number,
	output logic [rsrs_pkg::OFF_W-1:0]    chunk_offset,
	output logic [rsrs_pkg::LEN_W-1:0]    chunk_size,
	output logic [rsrs_pkg::BUF_W-1:0]    buffer_offset,
	output logic [rsrs_pkg::SRV_W-1:0]    server_0,
	output logic [rsrs_pkg::SRV_W-1:0]    server_1,
	output logic [rsrs_pkg::SRV_W-1:0]    server_2,
	output logic [rsrs_pkg::SRV_W-1:0]    server_3,
	output logic                          last_chunk
);

	logic [rsrs_pkg::KIB_W-1:0]   kib_q;
	logic [rsrs_pkg::NPOL_W-1:0]  npol_q;
	logic [rsrs_pkg::POL_SLOTS-1:0][rsrs_pkg::SRVW_W-1:0] width_q;

	rsrs_pkg::cfg_t cfg;
	logic           push_valid, push_ready, pop_valid, pop_ready;
	rsrs_pkg::job_t push_job, pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kib_q   <= rsrs_pkg::KIB_RST;
			npol_q  <= rsrs_pkg::NPOL_RST;
			width_q <= {rsrs_pkg::POL_SLOTS{rsrs_pkg::SRVW_RST}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsrs_pkg::REG_STRIPE_KIB:   kib_q      <= cfg_wdata;
				rsrs_pkg::REG_POLICY_COUNT: npol_q     <= cfg_wdata[rsrs_pkg::NPOL_W-1:0];
				rsrs_pkg::REG_WIDTH_0:      width_q[0] <= cfg_wdata[rsrs_pkg::SRVW_W-1:0];
				rsrs_pkg::REG_WIDTH_1:      width_q[1] <= cfg_wdata[rsrs_pkg::SRVW_W-1:0];
				rsrs_pkg::REG_WIDTH_2:      width_q[2] <= cfg_wdata[rsrs_pkg::SRVW_W-1:0];
				rsrs_pkg::REG_WIDTH_3:      width_q[3] <= cfg_wdata[rsrs_pkg::SRVW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.kib  = rsrs_pkg::clamp_kib(kib_q);
		cfg.npol = rsrs_pkg::clamp_npol(npol_q, rsrs_pkg::NPOL_W'(MAX_POLICIES));
		for (int i = 0; i < rsrs_pkg::POL_SLOTS; i++)
			cfg.width[i] = rsrs_pkg::clamp_width(width_q[i]);
	end

	rsrs_front #(.NUM_POL(MAX_POLICIES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.byte_offset(byte_offset),
		.byte_size  (byte_size),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	rsrs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job)
	);

	rsrs_back #(.NUM_POL(MAX_POLICIES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_job      (pop_job),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.object_number(object_number),
		.chunk_offset (chunk_offset),
		.chunk_size   (chunk_size),
		.buffer_offset(buffer_offset),
		.server_0     (server_0),
		.server_1     (server_1),
		.server_2     (server_2),
		.server_3     (server_3),
		.last_chunk   (last_chunk)
	);

endmodule

>>> sv/rsrs_front.sv
// ----------------------------------------------------------------------------
// rsrs_front
// Accepts a request, saturates its size and finds the first object number,
// in-object offset and server indices with a bit-serial divider.
// ----------------------------------------------------------------------------
module rsrs_front #(
	parameter int NUM_POL = rsrs_pkg::MAX_POL_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [rsrs_pkg::BASE_W-1:0]   byte_offset,
	input  logic [rsrs_pkg::SIZE_W-1:0]   byte_size,
	input  rsrs_pkg::cfg_t                cfg,
	output logic                          push_valid,
	input  logic                          push_ready,
	output rsrs_pkg::job_t                push_job
);

	rsrs_pkg::front_state_t state_q, state_d;

	logic [rsrs_pkg::DIV_BITS-1:0] quo_q;
	logic [rsrs_pkg::KIB_W-1:0]    rem_q;
	logic [rsrs_pkg::LOW_W-1:0]    low_q;
	logic [rsrs_pkg::SIZE_W-1:0]   size_q;
	logic                          kind_q;
	logic [rsrs_pkg::CNT_W-1:0]    cnt_q;
	logic [NUM_POL-1:0][rsrs_pkg::SRV_W-1:0] mod_q;

	logic [rsrs_pkg::SIZE_W-1:0]   size_sat;
	logic [rsrs_pkg::KIB_W:0]      trial;
	logic                          qbit;
	logic [rsrs_pkg::KIB_W-1:0]    rem_next;
	logic                          accept;

	assign accept   = in_valid && in_ready;
	assign size_sat = byte_size[rsrs_pkg::SIZE_W-1] ? rsrs_pkg::SIZE_BOUND : byte_size;

	// one quotient bit per cycle, msb first
	assign trial    = {rem_q, quo_q[rsrs_pkg::DIV_BITS-1]};
	assign qbit     = (trial >= {1'b0, cfg.kib});
	assign rem_next = qbit ? rsrs_pkg::KIB_W'(trial - {1'b0, cfg.kib})
		: rsrs_pkg::KIB_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsrs_pkg::FS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				cnt_q <= '0;
			else if (state_q == rsrs_pkg::FS_DIV)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			quo_q  <= byte_offset[rsrs_pkg::BASE_W-1:rsrs_pkg::LOW_W];
			low_q  <= byte_offset[rsrs_pkg::LOW_W-1:0];
			rem_q  <= '0;
			size_q <= size_sat;
			kind_q <= req_type;
		end else if (state_q == rsrs_pkg::FS_DIV) begin
			quo_q <= {quo_q[rsrs_pkg::DIV_BITS-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	// running object number modulo each policy width, fed by the quotient bits
	for (genvar i = 0; i < NUM_POL; i++) begin : g_mod
		logic [rsrs_pkg::SRVW_W-1:0] mt;
		assign mt = {mod_q[i], qbit};
		always_ff @(posedge clk) begin
			if (accept)
				mod_q[i] <= '0;
			else if (state_q == rsrs_pkg::FS_DIV)
				mod_q[i] <= (mt >= cfg.width[i]) ? rsrs_pkg::SRV_W'(mt - cfg.width[i])
					: rsrs_pkg::SRV_W'(mt);
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			rsrs_pkg::FS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && size_sat != '0)
					state_d = rsrs_pkg::FS_DIV;
			end
			rsrs_pkg::FS_DIV: begin
				if (cnt_q == rsrs_pkg::DIV_LAST)
					state_d = rsrs_pkg::FS_PUSH;
			end
			rsrs_pkg::FS_PUSH: begin
				push_valid = 1'b1;
				if (push_ready)
					state_d = rsrs_pkg::FS_IDLE;
			end
			default: state_d = rsrs_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		push_job      = '0;
		push_job.kind = kind_q;
		push_job.obj  = quo_q;
		push_job.off  = {rem_q[rsrs_pkg::OFF_W-rsrs_pkg::LOW_W-1:0], low_q};
		push_job.size = size_q;
		for (int i = 0; i < NUM_POL; i++)
			push_job.srv[i] = mod_q[i];
	end

endmodule

>>> sv/rsrs_fifo.sv
// ----------------------------------------------------------------------------
// rsrs_fifo
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module rsrs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rsrs_pkg::job_t  push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rsrs_pkg::job_t  pop_job
);

	rsrs_pkg::job_t mem_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= ~wptr_q;
			if (do_pop)
				rptr_q <= ~rptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= push_job;
	end

endmodule

>>> sv/rsrs_back.sv
// ----------------------------------------------------------------------------
// rsrs_back
// Walks a classified request stripe by stripe and emits one chunk per cycle
// into an output register while that register is empty or out_ready is high.
// ----------------------------------------------------------------------------
module rsrs_back #(
	parameter int NUM_POL = rsrs_pkg::MAX_POL_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsrs_pkg::cfg_t                cfg,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  rsrs_pkg::job_t                pop_job,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [rsrs_pkg::OBJ_W-1:0]    object_number,
	output logic [rsrs_pkg::OFF_W-1:0]    chunk_offset,
	output logic [rsrs_pkg::LEN_W-1:0]    chunk_size,
	output logic [rsrs_pkg::BUF_W-1:0]    buffer_offset,
	output logic [rsrs_pkg::SRV_W-1:0]    server_0,
	output logic [rsrs_pkg::SRV_W-1:0]    server_1,
	output logic [rsrs_pkg::SRV_W-1:0]    server_2,
	output logic [rsrs_pkg::SRV_W-1:0]    server_3,
	output logic                          last_chunk
);

	logic                           active_q;
	rsrs_pkg::job_t                 job_q;
	logic [rsrs_pkg::SIZE_W-1:0]    done_q;
	logic                           out_valid_q;
	logic                           kind_q, last_q;
	logic [rsrs_pkg::DIV_BITS-1:0]  obj_q;
	logic [rsrs_pkg::OFF_W-1:0]     off_q;
	logic [rsrs_pkg::LEN_W-1:0]     len_q;
	logic [rsrs_pkg::BUF_W-1:0]     buf_q;
	logic [rsrs_pkg::POL_SLOTS-1:0][rsrs_pkg::SRV_W-1:0] srv_q;

	logic [rsrs_pkg::LEN_W-1:0]     stripe_bytes;
	logic [rsrs_pkg::LEN_W-1:0]     room;
	logic                           is_last;
	logic [rsrs_pkg::LEN_W-1:0]     len;
	logic                           advance;
	logic [rsrs_pkg::POL_SLOTS-1:0][rsrs_pkg::SRV_W-1:0] srv_next;

	assign stripe_bytes = {cfg.kib, {rsrs_pkg::LOW_W{1'b0}}};
	assign room         = stripe_bytes - rsrs_pkg::LEN_W'(job_q.off);
	assign is_last      = (rsrs_pkg::LEN_W'(job_q.size) <= room);
	assign len          = is_last ? rsrs_pkg::LEN_W'(job_q.size) : room;
	assign advance      = !out_valid_q || out_ready;
	assign pop_ready    = !active_q;

	// next object's server index: step by one with wrap
	always_comb begin
		srv_next = '0;
		for (int i = 0; i < NUM_POL; i++)
			srv_next[i] = ({1'b0, job_q.srv[i]} + 1'b1 == cfg.width[i]) ? '0
				: job_q.srv[i] + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!active_q)
				active_q <= pop_valid;
			else if (advance && is_last)
				active_q <= 1'b0;
			if (advance)
				out_valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (!active_q) begin
			job_q  <= pop_job;
			done_q <= '0;
		end else if (advance) begin
			job_q.obj  <= job_q.obj + 1'b1;
			job_q.off  <= '0;
			job_q.size <= job_q.size - rsrs_pkg::SIZE_W'(len);
			job_q.srv  <= srv_next;
			done_q     <= done_q + rsrs_pkg::SIZE_W'(len);
		end
		if (active_q && advance) begin
			kind_q <= job_q.kind;
			obj_q  <= job_q.obj;
			off_q  <= job_q.off;
			len_q  <= len;
			buf_q  <= done_q[rsrs_pkg::BUF_W-1:0];
			srv_q  <= job_q.srv;
			last_q <= is_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign object_number = rsrs_pkg::OBJ_W'(obj_q);
	assign chunk_offset  = off_q;
	assign chunk_size    = len_q;
	assign buffer_offset = buf_q;
	assign last_chunk    = last_q;
	assign server_0      = (cfg.npol > 3'd0) ? srv_q[0] : '0;
	assign server_1      = (cfg.npol > 3'd1) ? srv_q[1] : '0;
	assign server_2      = (cfg.npol > 3'd2) ? srv_q[2] : '0;
	assign server_3      = (cfg.npol > 3'd3) ? srv_q[3] : '0;

endmodule

>>> sv/rsrs_checker.sv
// ----------------------------------------------------------------------------
// rsrs_checker
// Port-level checks for the stripe request splitter, bound to the top level.
// ----------------------------------------------------------------------------
module rsrs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [rsrs_pkg::SIZE_W-1:0]   byte_size,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [rsrs_pkg::OBJ_W-1:0]    object_number,
	input  logic [rsrs_pkg::LEN_W-1:0]    chunk_size
);

	// a stalled chunk holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(object_number)
			&& $stable(chunk_size))
		else $error("stalled chunk changed");

	// a chunk is never empty and never larger than the size bound
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chunk_size != '0
			&& chunk_size <= rsrs_pkg::LEN_W'(rsrs_pkg::SIZE_BOUND))
		else $error("chunk size out of range");

	// an accepted nonempty request drops in_ready, as the front starts dividing
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && byte_size != '0 |=> !in_ready)
		else $error("front took a request while dividing");

endmodule

bind raid0_stripe_request_splitter_unit rsrs_checker u_rsrs_checker (.*);

>>> dv/raid0_stripe_chunk_checker.sv
// ----------------------------------------------------------------------------
// raid0_stripe_chunk_checker
// Watches the request and chunk channels of the stripe splitter, computes
// the chunks each accepted request must produce and compares them in order.
// ----------------------------------------------------------------------------
module raid0_stripe_chunk_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rsrs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [rsrs_pkg::KIB_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          req_type,
	input  logic [rsrs_pkg::BASE_W-1:0]   byte_offset,
	input  logic [rsrs_pkg::SIZE_W-1:0]   byte_size,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          kind,
	input  logic [rsrs_pkg::OBJ_W-1:0]    object_number,
	input  logic [rsrs_pkg::OFF_W-1:0]    chunk_offset,
	input  logic [rsrs_pkg::LEN_W-1:0]    chunk_size,
	input  logic [rsrs_pkg::BUF_W-1:0]    buffer_offset,
	input  logic [rsrs_pkg::SRV_W-1:0]    server_0,
	input  logic [rsrs_pkg::SRV_W-1:0]    server_1,
	input  logic [rsrs_pkg::SRV_W-1:0]    server_2,
	input  logic [rsrs_pkg::SRV_W-1:0]    server_3,
	input  logic                          last_chunk,
	output int                            fail_count,
	output int                            chunks_pending
);
	import rsrs_pkg::*;

	typedef struct {
		logic             kind;
		logic [OBJ_W-1:0] obj;
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic [BUF_W-1:0] buf_off;
		logic [SRV_W-1:0] srv [4];
		logic             last;
	} chunk_t;

	chunk_t chunk_q[$];
	logic [KIB_W-1:0]  stripe_kib_r;
	logic [NPOL_W-1:0] npol_r;
	logic [SRVW_W-1:0] width_r [4];

	task automatic report(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	task automatic split_request(input logic rt, input logic [BASE_W-1:0] base,
		input logic [SIZE_W-1:0] sz);
		longint unsigned stripe, npol, size, done, pos, obj, off, len, w;
		chunk_t c;
		stripe = 64'(stripe_kib_r);
		if (stripe < 64'd32) stripe = 64'd32;
		if (stripe > 64'd65536) stripe = 64'd65536;
		stripe = stripe * 64'd1024;
		npol = 64'(npol_r);
		if (npol == 64'd0) npol = 64'd1;
		if (npol > 64'd4) npol = 64'd4;
		size = 64'(sz);
		if (size > 64'h100000) size = 64'h100000;
		done = 64'd0;
		while (done < size) begin
			pos = 64'(base) + done;
			obj = pos / stripe;
			off = pos % stripe;
			len = size - done;
			if (len > stripe - off) len = stripe - off;
			c.kind = rt;
			c.obj = obj[OBJ_W-1:0];
			c.off = off[OFF_W-1:0];
			c.len = len[LEN_W-1:0];
			c.buf_off = done[BUF_W-1:0];
			for (int p = 0; p < 4; p++) begin
				w = 64'(width_r[p]);
				if (w == 64'd0) w = 64'd1;
				if (w > 64'd256) w = 64'd256;
				c.srv[p] = (64'(p) < npol) ? SRV_W'(obj % w) : '0;
			end
			done += len;
			c.last = (done >= size);
			chunk_q.insert(chunk_q.size(), c);
		end
	endtask

	assign chunks_pending = chunk_q.size();

	always @(posedge clk or negedge arst_n) begin
		chunk_t e;
		logic [SRV_W-1:0] got_srv [4];
		if (!arst_n) begin
			stripe_kib_r <= KIB_RST;
			npol_r <= NPOL_RST;
			for (int i = 0; i < 4; i++) width_r[i] <= SRVW_RST;
			chunk_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STRIPE_KIB:   stripe_kib_r <= cfg_wdata;
					REG_POLICY_COUNT: npol_r <= cfg_wdata[NPOL_W-1:0];
					REG_WIDTH_0:      width_r[0] <= cfg_wdata[SRVW_W-1:0];
					REG_WIDTH_1:      width_r[1] <= cfg_wdata[SRVW_W-1:0];
					REG_WIDTH_2:      width_r[2] <= cfg_wdata[SRVW_W-1:0];
					REG_WIDTH_3:      width_r[3] <= cfg_wdata[SRVW_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (chunk_q.size() == 0) begin
					report("unexpected chunk obj", 64'(object_number), '0);
				end else begin
					e = chunk_q.pop_front();
					got_srv = '{server_0, server_1, server_2, server_3};
					if (kind !== e.kind) report("kind", 64'(kind), 64'(e.kind));
					if (object_number !== e.obj)
						report("object_number", 64'(object_number), 64'(e.obj));
					if (chunk_offset !== e.off)
						report("chunk_offset", 64'(chunk_offset), 64'(e.off));
					if (chunk_size !== e.len)
						report("chunk_size", 64'(chunk_size), 64'(e.len));
					if (buffer_offset !== e.buf_off)
						report("buffer_offset", 64'(buffer_offset), 64'(e.buf_off));
					for (int p = 0; p < 4; p++)
						if (got_srv[p] !== e.srv[p]) report($sformatf("server_%0d", p),
							64'(got_srv[p]), 64'(e.srv[p]));
					if (last_chunk !== e.last)
						report("last_chunk", 64'(last_chunk), 64'(e.last));
				end
			end
			// requests use the config as it stood before this edge
			if (in_valid && in_ready) split_request(req_type, byte_offset, byte_size);
		end
	end
endmodule

>>> dv/tb_raid0_stripe_request_splitter_unit.sv
// ----------------------------------------------------------------------------
// tb_raid0_stripe_request_splitter_unit
// Drives directed and random requests through several stripe and policy
// settings with random idling on both channels; the checker judges chunks.
// ----------------------------------------------------------------------------
module tb_raid0_stripe_request_splitter_unit;
	import rsrs_pkg::*;

	logic clk, arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [KIB_W-1:0] cfg_wdata;
	logic in_valid, in_ready, req_type;
	logic [BASE_W-1:0] byte_offset;
	logic [SIZE_W-1:0] byte_size;
	logic out_valid, out_ready, kind, last_chunk;
	logic [OBJ_W-1:0] object_number;
	logic [OFF_W-1:0] chunk_offset;
	logic [LEN_W-1:0] chunk_size;
	logic [BUF_W-1:0] buffer_offset;
	logic [SRV_W-1:0] server_0, server_1, server_2, server_3;
	int fail_count, chunks_pending;
	bit hold_off;

	raid0_stripe_request_splitter_unit dut (.*);
	raid0_stripe_chunk_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: random stall per transfer, one long hold-off on request
	initial begin
		int n;
		bit held;
		out_ready = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off && !held) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				held = 1;
			end
			n = int'($urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0) n = 0;
			if (n > 0) begin
				out_ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [KIB_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send(input logic t, input logic [BASE_W-1:0] off,
		input logic [SIZE_W-1:0] sz, input bit gaps);
		int n;
		n = gaps ? int'($urandom_range(0, 7)) : 0;
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= t;
		byte_offset <= off;
		byte_size <= sz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (chunks_pending != 0) @(posedge clk);
		// let the block settle before the next register writes
		repeat (100) @(posedge clk);
	endtask

	task automatic rand_request(input int kib);
		logic [BASE_W-1:0] off;
		logic [SIZE_W-1:0] sz;
		longint unsigned stripe;
		stripe = 64'(kib) * 64'd1024;
		off = BASE_W'({$urandom, $urandom});
		case ($urandom_range(0, 5))
			0: sz = SIZE_W'($urandom_range(1, 64));
			1: sz = SIZE_W'($urandom_range(1, 21'h1FFFFF));
			2: sz = 21'h100000;
			3: begin
				off = BASE_W'((64'(off) / stripe) * stripe + stripe
					- 64'($urandom_range(1, 8)));
				sz = SIZE_W'($urandom_range(1, 64));
			end
			4: sz = '0;
			default: sz = SIZE_W'($urandom_range(1, 300000));
		endcase
		send(1'($urandom_range(0, 1)), off, sz, 1'b1);
	endtask

	initial begin
		int kibs [5];
		cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
		in_valid = 0; req_type = 0; byte_offset = '0; byte_size = '0;
		hold_off = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed at reset config
		send(1'b0, '0, 21'd1, 1'b0);
		send(1'b1, '1, 21'h1FFFFF, 1'b0);
		send(1'b0, 48'd131071, 21'd2, 1'b0);
		send(1'b1, 48'd12345, 21'd0, 1'b0);
		send(1'b0, 48'd131072, 21'h100001, 1'b0);
		send(1'b1, 48'h555555555555, 21'h0AAAAA, 1'b0);
		send(1'b0, 48'hAAAAAAAAAAAA, 21'h155555, 1'b0);
		drain();

		// minimum stripe and all four policies with extreme widths
		write_reg(REG_STRIPE_KIB, 17'd32);
		write_reg(REG_POLICY_COUNT, 17'd4);
		write_reg(REG_WIDTH_0, 17'd256);
		write_reg(REG_WIDTH_1, 17'd1);
		write_reg(REG_WIDTH_2, 17'd0);
		write_reg(REG_WIDTH_3, 17'h1FF);
		send(1'b0, 48'd32767, 21'h100000, 1'b0);
		send(1'b1, '1, 21'd100, 1'b0);
		send(1'b0, 48'd0, 21'h100000, 1'b0);
		hold_off = 1;
		for (int i = 0; i < 6; i++) send(1'($urandom_range(0, 1)),
			BASE_W'({$urandom, $urandom}), SIZE_W'($urandom_range(1, 200000)), 1'b0);
		drain();

		// out-of-range stripe and policy count; unknown indexes ignored
		write_reg(REG_STRIPE_KIB, 17'd5);
		write_reg(REG_POLICY_COUNT, 17'd0);
		write_reg(reg_idx_t'(3'd6), 17'h1FFFF);
		write_reg(reg_idx_t'(3'd7), 17'h1FFFF);
		send(1'b1, 48'd70000, 21'd90000, 1'b0);
		drain();
		write_reg(REG_STRIPE_KIB, 17'h1FFFF);
		write_reg(REG_POLICY_COUNT, 17'd7);
		send(1'b0, 48'h3FFFFFFF0, 21'h100000, 1'b0);
		send(1'b1, '1, 21'h1FFFFF, 1'b0);
		drain();

		kibs = '{128, 32, 65536, 1000, 32};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_STRIPE_KIB,
				KIB_W'(ph == 3 ? $urandom_range(32, 65536) : kibs[ph]));
			write_reg(REG_POLICY_COUNT, KIB_W'($urandom_range(0, 7)));
			write_reg(REG_WIDTH_0, KIB_W'($urandom_range(0, 511)));
			write_reg(REG_WIDTH_1, KIB_W'($urandom_range(0, 511)));
			write_reg(REG_WIDTH_2, KIB_W'($urandom_range(0, 511)));
			write_reg(REG_WIDTH_3, KIB_W'($urandom_range(0, 511)));
			for (int i = 0; i < 22; i++)
				rand_request(ph == 3 ? 32 : kibs[ph]);
			drain();
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

>>> filelist.f
sv/rsrs_pkg.sv
sv/rsrs_front.sv
sv/rsrs_fifo.sv
sv/rsrs_back.sv
sv/raid0_stripe_request_splitter_unit.sv
sv/rsrs_checker.sv
dv/raid0_stripe_chunk_checker.sv
dv/tb_raid0_stripe_request_splitter_unit.sv
